// ===== rtl/differential_drive_odometry_core_macros.svh =====
// Assertion macros for the odometry core.
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_CORE_MACROS_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ODO_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define ODO_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ODO_ASSERT(lbl, prop, msg)
`define ODO_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/odo_pkg.sv =====
// Shared constants, types and the arctangent table of the odometry core.
package odo_pkg;
	localparam int IN_W  = 24;
	localparam int OUT_W = 32;
	localparam int RAD_W = 20;
	localparam int BASE_W = 22;
	localparam int CORDIC_STEPS = 30;
	localparam int RED_STEPS = 10;

	localparam logic [RAD_W-1:0]  RADIUS_RST = 20'd36700;
	localparam logic [BASE_W-1:0] BASE_RST   = 22'd235930;

	localparam logic [32:0] TWO_PI_Q30  = 33'd6746518852;
	localparam logic [32:0] PI_Q30      = 33'd3373259426;
	localparam logic [32:0] HALF_PI_Q30 = 33'd1686629713;
	localparam logic [31:0] GAIN_Q30    = 32'd652032874;

	typedef enum logic {
		REG_RADIUS = 1'b0,
		REG_BASE   = 1'b1
	} reg_idx_t;

	function automatic logic [29:0] atan_lut(input logic [4:0] i);
		logic [29:0] v;
		case (i)
			5'd0:  v = 30'd843314857;
			5'd1:  v = 30'd497837829;
			5'd2:  v = 30'd263043837;
			5'd3:  v = 30'd133525159;
			5'd4:  v = 30'd67021687;
			5'd5:  v = 30'd33543516;
			5'd6:  v = 30'd16775851;
			5'd7:  v = 30'd8388437;
			5'd8:  v = 30'd4194283;
			5'd9:  v = 30'd2097149;
			5'd10: v = 30'd1048576;
			5'd11: v = 30'd524288;
			5'd12: v = 30'd262144;
			5'd13: v = 30'd131072;
			5'd14: v = 30'd65536;
			5'd15: v = 30'd32768;
			5'd16: v = 30'd16384;
			5'd17: v = 30'd8192;
			5'd18: v = 30'd4096;
			5'd19: v = 30'd2048;
			5'd20: v = 30'd1024;
			5'd21: v = 30'd512;
			5'd22: v = 30'd256;
			5'd23: v = 30'd128;
			5'd24: v = 30'd64;
			5'd25: v = 30'd32;
			5'd26: v = 30'd16;
			5'd27: v = 30'd8;
			5'd28: v = 30'd4;
			5'd29: v = 30'd2;
			default: v = 30'd0;
		endcase
		return v;
	endfunction
endpackage

// ===== rtl/odo_if.sv =====
// Valid/ready channel interfaces for wheel increments and pose results.
interface odo_req_if;
	logic valid;
	logic ready;
	logic signed [odo_pkg::IN_W-1:0] dphi_left;
	logic signed [odo_pkg::IN_W-1:0] dphi_right;
	modport source(output valid, dphi_left, dphi_right, input ready);
	modport sink(input valid, dphi_left, dphi_right, output ready);
endinterface

interface odo_rsp_if;
	logic valid;
	logic ready;
	logic signed [odo_pkg::OUT_W-1:0] x_pos;
	logic signed [odo_pkg::OUT_W-1:0] y_pos;
	logic signed [odo_pkg::OUT_W-1:0] heading_out;
	logic [odo_pkg::OUT_W-1:0] path_length;
	modport source(output valid, x_pos, y_pos, heading_out, path_length, input ready);
	modport sink(input valid, x_pos, y_pos, heading_out, path_length, output ready);
endinterface

// ===== rtl/differential_drive_odometry_core.sv =====
// Top level of the differential-drive odometry core: sequencer, state and APB registers.
//
// Usage:
//   req carries one item per control period: left and right wheel angle
//   increments (signed, 2^-20 rad). rsp returns one item per request: X, Y,
//   unwrapped heading and path length (2^-20 m / rad), all saturating.
//   The APB port holds wheel_radius (addr 0) and wheel_base (addr 4);
//   write them only while no item is in flight.
// Sequence:
//   An item passes from acceptance to rsp.valid through the serial heading
//   divide, angle reduction (10) plus 30 CORDIC iterations, six passes
//   through the one shared multiplier and the 24-step square root.
//   req.ready is high only while the sequencer is idle, so a new item is not
//   taken until the last one has reached the output register; a stalled rsp can hold that up.
// Stall:
//   Results sit in an output register; a new item may be accepted and
//   worked on while rsp waits. If the next result is done before rsp drains,
//   the sequencer holds until the register frees.
// Reset:
//   arst_n clears heading, X, Y and path length to zero and loads the
//   register defaults (radius 36700, base 235930).
`include "differential_drive_odometry_core_macros.svh"
module differential_drive_odometry_core (
	input  logic                clk,
	input  logic                arst_n,
	odo_req_if.sink             req,
	odo_rsp_if.source           rsp,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import odo_pkg::*;

	typedef enum logic [12:0] {
		S_IDLE   = 13'b0000000000001,
		S_MNUM   = 13'b0000000000010,
		S_DSTART = 13'b0000000000100,
		S_DWAIT  = 13'b0000000001000,
		S_CSTART = 13'b0000000010000,
		S_CWAIT  = 13'b0000000100000,
		S_MDX    = 13'b0000001000000,
		S_MDY    = 13'b0000010000000,
		S_MSX    = 13'b0000100000000,
		S_MSY    = 13'b0001000000000,
		S_SSTART = 13'b0010000000000,
		S_SWAIT  = 13'b0100000000000,
		S_OUT    = 13'b1000000000000
	} state_t;

	function automatic logic signed [31:0] sat47(input logic signed [46:0] v);
		if (v > 47'sd2147483647) return 32'sh7fffffff;
		if (v < -47'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
		if (v[32] != v[31]) return v[32] ? 32'sh80000000 : 32'sh7fffffff;
		return v[31:0];
	endfunction

	state_t              state_q;
	logic [RAD_W-1:0]    radius_q;
	logic [BASE_W-1:0]   base_q;
	logic signed [23:0]  dl_q, dr_q;
	logic signed [31:0]  heading_q, x_q, y_q;
	logic [31:0]         dist_q;
	logic                num_neg_q;
	logic signed [32:0]  d_q;
	logic signed [25:0]  dx_q, dy_q;
	logic [47:0]         sq_q;
	logic                rsp_valid_q;
	logic signed [31:0]  x_out_q, y_out_q, h_out_q;
	logic [31:0]         p_out_q;

	// shared multiplier
	logic signed [33:0]  mul_a;
	logic signed [31:0]  mul_b;
	logic                mul_en;
	logic signed [65:0]  prod_q;

	logic signed [24:0]  wdiff, wsum;
	logic [21:0]         base_eff;
	logic [44:0]         num_mag;
	logic                div_done;
	logic [44:0]         quo;
	logic signed [46:0]  hsum;
	logic                cor_done;
	logic signed [31:0]  cos_v, sin_v;
	logic signed [45:0]  d_rnd;
	logic signed [63:0]  p_rnd;
	logic                sq_done;
	logic [24:0]         root;
	logic signed [32:0]  xsum, ysum;
	logic [32:0]         dsum;
	logic                out_load;

	assign wdiff    = 25'(dr_q) - 25'(dl_q);
	assign wsum     = 25'(dr_q) + 25'(dl_q);
	// a zero wheel base acts as one
	assign base_eff = (base_q == '0) ? 22'd1 : base_q;
	assign num_mag  = prod_q[65] ? 45'(-prod_q[44:0]) : prod_q[44:0];
	assign hsum     = 47'(heading_q) + (num_neg_q ? -47'(quo) : 47'(quo));
	// round half up, floor shift
	assign d_rnd    = prod_q[45:0] + 46'sd4096;
	assign p_rnd    = prod_q[63:0] + (64'sd1 <<< 37);
	assign xsum     = 33'(x_q) + 33'(dx_q);
	assign ysum     = 33'(y_q) + 33'(dy_q);
	assign dsum     = {1'b0, dist_q} + 33'(root);
	assign out_load = (state_q == S_OUT) && (!rsp_valid_q || rsp.ready);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_MNUM: begin
				mul_a = {14'b0, radius_q};
				mul_b = 32'(wdiff);
			end
			S_CSTART: begin
				mul_a = {14'b0, radius_q};
				mul_b = 32'(wsum);
			end
			S_MDX: begin
				mul_a = 34'(d_q);
				mul_b = cos_v;
			end
			S_MDY: begin
				mul_a = 34'(d_q);
				mul_b = sin_v;
			end
			S_MSX: begin
				mul_a = 34'(dx_q);
				mul_b = 32'(dx_q);
			end
			S_MSY: begin
				mul_a = 34'(dy_q);
				mul_b = 32'(dy_q);
			end
			default: ;
		endcase
	end

	assign mul_en = state_q inside {S_MNUM, S_CSTART, S_MDX, S_MDY, S_MSX, S_MSY};

	odo_mul u_mul (
		.clk    (clk),
		.en     (mul_en),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	odo_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_DSTART),
		.dividend (num_mag + 45'(base_eff)),
		.divisor  ({base_eff, 1'b0}),
		.done_q   (div_done),
		.quo_q    (quo)
	);

	odo_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == S_CSTART),
		.heading (heading_q),
		.done_q  (cor_done),
		.cos_q   (cos_v),
		.sin_q   (sin_v)
	);

	odo_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_SSTART),
		.radicand (sq_q + prod_q[47:0]),
		.done_q   (sq_done),
		.root_q   (root)
	);

	// sequencer and odometry state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			heading_q   <= '0;
			x_q         <= '0;
			y_q         <= '0;
			dist_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (out_load) rsp_valid_q <= 1'b1;
			else if (rsp.ready) rsp_valid_q <= 1'b0;
			case (state_q)
				S_IDLE:   if (req.valid) state_q <= S_MNUM;
				S_MNUM:   state_q <= S_DSTART;
				S_DSTART: state_q <= S_DWAIT;
				S_DWAIT: begin
					if (div_done) begin
						heading_q <= sat47(hsum);
						state_q   <= S_CSTART;
					end
				end
				S_CSTART: state_q <= S_CWAIT;
				S_CWAIT:  if (cor_done) state_q <= S_MDX;
				S_MDX:    state_q <= S_MDY;
				S_MDY:    state_q <= S_MSX;
				S_MSX:    state_q <= S_MSY;
				S_MSY:    state_q <= S_SSTART;
				S_SSTART: begin
					x_q     <= sat33(xsum);
					y_q     <= sat33(ysum);
					state_q <= S_SWAIT;
				end
				S_SWAIT: begin
					if (sq_done) begin
						dist_q  <= dsum[32] ? 32'hffffffff : dsum[31:0];
						state_q <= S_OUT;
					end
				end
				S_OUT:    if (out_load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.valid) begin
			dl_q <= req.dphi_left;
			dr_q <= req.dphi_right;
		end
		if (state_q == S_DSTART) num_neg_q <= prod_q[65];
		if (state_q == S_CWAIT && cor_done) d_q <= d_rnd[45:13];
		if (state_q == S_MDY) dx_q <= p_rnd[63:38];
		if (state_q == S_MSX) dy_q <= p_rnd[63:38];
		if (state_q == S_MSY) sq_q <= prod_q[47:0];
		if (out_load) begin
			x_out_q <= x_q;
			y_out_q <= y_q;
			h_out_q <= heading_q;
			p_out_q <= dist_q;
		end
	end

	assign req.ready       = (state_q == S_IDLE);
	assign rsp.valid       = rsp_valid_q;
	assign rsp.x_pos       = x_out_q;
	assign rsp.y_pos       = y_out_q;
	assign rsp.heading_out = h_out_q;
	assign rsp.path_length = p_out_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RST;
			base_q   <= BASE_RST;
		end else if (psel && penable && pwrite) begin
			if (reg_idx_t'(paddr[2]) == REG_RADIUS) radius_q <= pwdata[RAD_W-1:0];
			else base_q <= pwdata[BASE_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (reg_idx_t'(paddr[2]) == REG_RADIUS) ? {12'b0, radius_q}
		: {10'b0, base_q};

	`ODO_ASSERT(a_accept_starts, (req.valid && req.ready) |=> (state_q == S_MNUM), "accepted item did not start the sequence")
	`ODO_ASSERT(a_heading_hold, !(state_q == S_DWAIT && div_done) |=> $stable(heading_q), "heading changed outside its update step")
	`ODO_ASSERT(a_path_monotone, 1'b1 |=> (dist_q >= $past(dist_q)), "path length decreased")
	`ODO_ASSERT_ALWAYS(a_root_in_wait, sq_done |-> (state_q == S_SWAIT), "square root finished outside its wait state")
endmodule

// ===== rtl/odo_mul.sv =====
// Shared signed multiplier with registered product.
module odo_mul (
	input  logic               clk,
	input  logic               en,
	input  logic signed [33:0] a,
	input  logic signed [31:0] b,
	output logic signed [65:0] prod_q
);
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= 66'(a) * 66'(b);
		end
	end
endmodule

// ===== rtl/odo_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
module odo_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [44:0] dividend,
	input  logic [22:0] divisor,
	output logic        done_q,
	output logic [44:0] quo_q
);
	logic [22:0] rem_q;
	logic [22:0] div_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [23:0] trial;
	logic        fits;

	assign trial = {rem_q, quo_q[44]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd44;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? 23'(trial - {1'b0, div_q}) : trial[22:0];
			quo_q <= {quo_q[43:0], fits};
		end
	end
endmodule

// ===== rtl/odo_sqrt.sv =====
// Digit-by-digit square root with round to nearest, two radicand bits per cycle.
module odo_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [47:0] radicand,
	output logic        done_q,
	output logic [24:0] root_q
);
	logic [47:0] rem_q;
	logic [47:0] res_q;
	logic [47:0] bit_q;
	logic        busy_q;
	logic [47:0] trial;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= radicand;
			res_q <= '0;
			bit_q <= 48'd1 << 46;
		end else if (busy_q) begin
			if (bit_q == '0) begin
				// final remainder is n - res^2; round up when it exceeds res
				root_q <= (rem_q > res_q) ? 25'(res_q + 48'd1) : res_q[24:0];
			end else begin
				if (rem_q >= trial) begin
					rem_q <= rem_q - trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
		end
	end
endmodule

// ===== rtl/odo_cordic.sv =====
// Angle reduction and iterative CORDIC rotation giving cosine and sine in Q30.
module odo_cordic (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] heading,
	output logic               done_q,
	output logic signed [31:0] cos_q,
	output logic signed [31:0] sin_q
);
	import odo_pkg::*;

	typedef enum logic [5:0] {
		C_IDLE  = 6'b000001,
		C_RED   = 6'b000010,
		C_FOLD1 = 6'b000100,
		C_FOLD2 = 6'b001000,
		C_ROT   = 6'b010000,
		C_FIN   = 6'b100000
	} cstate_t;

	localparam logic [42:0] TWO_PI_43  = {10'b0, TWO_PI_Q30};
	localparam logic signed [33:0] T_S = {1'b0, TWO_PI_Q30};
	localparam logic signed [33:0] P_S = {1'b0, PI_Q30};
	localparam logic signed [33:0] H_S = {1'b0, HALF_PI_Q30};

	cstate_t            st_q;
	logic [42:0]        v_q;
	logic [3:0]         k_q;
	logic [4:0]         i_q;
	logic signed [33:0] x_q, y_q, z_q;
	logic               flip_q;
	logic [42:0]        sub;
	logic signed [33:0] xs, ys, at;

	assign sub = TWO_PI_43 << k_q;
	assign xs  = x_q >>> i_q;
	assign ys  = y_q >>> i_q;
	assign at  = {4'b0, atan_lut(i_q)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= C_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				C_IDLE:  if (start) st_q <= C_RED;
				C_RED:   if (k_q == '0) st_q <= C_FOLD1;
				C_FOLD1: st_q <= C_FOLD2;
				C_FOLD2: st_q <= C_ROT;
				C_ROT:   if (i_q == 5'(CORDIC_STEPS - 1)) st_q <= C_FIN;
				C_FIN: begin
					st_q   <= C_IDLE;
					done_q <= 1'b1;
				end
				default: st_q <= C_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			C_IDLE: begin
				// offset by 512 turns so the value is never negative
				v_q <= 43'({{11{heading[31]}}, heading} <<< 10) + (TWO_PI_43 << 9);
				k_q <= 4'(RED_STEPS - 1);
			end
			C_RED: begin
				if (v_q >= sub) v_q <= v_q - sub;
				k_q <= k_q - 4'd1;
			end
			C_FOLD1: begin
				z_q <= ($signed(v_q[33:0]) > P_S) ? $signed(v_q[33:0]) - T_S
					: $signed(v_q[33:0]);
			end
			C_FOLD2: begin
				flip_q <= 1'b0;
				if (z_q > H_S) begin
					z_q    <= z_q - P_S;
					flip_q <= 1'b1;
				end else if (z_q < -H_S) begin
					z_q    <= z_q + P_S;
					flip_q <= 1'b1;
				end
				x_q <= {2'b0, GAIN_Q30};
				y_q <= '0;
				i_q <= '0;
			end
			C_ROT: begin
				if (z_q >= 0) begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - at;
				end else begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + at;
				end
				i_q <= i_q + 5'd1;
			end
			C_FIN: begin
				cos_q <= flip_q ? 32'(-x_q) : x_q[31:0];
				sin_q <= flip_q ? 32'(-y_q) : y_q[31:0];
			end
			default: ;
		endcase
	end
endmodule
